@@ design/gbfp_pkg.sv @@
// Package for the binary frame parser: event codes, register indexes,
// result record type and the byte-wide reflected CRC-32 update.
// No dependencies.
package gbfp_pkg;

  // Event codes on the result channel
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_GOOD    = 3'd2;
  localparam logic [2:0] EV_BAD     = 3'd3;
  localparam logic [2:0] EV_ABORT   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_SYNC_THIRD  = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h44;
  localparam logic [7:0] SYNC_THIRD_RST  = 8'h12;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [7:0]  FIXED_HEADER = 8'd4;

  // One result item
  typedef struct packed {
    logic [2:0]  event_code;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [15:0] message_id;
    logic [10:0] frame_bytes;
  } result_t;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/gbfp_if.sv @@
// Handshake interfaces for the frame parser: received byte channel and
// result channel.

interface gbfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface gbfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_code;
  logic [7:0]  payload_byte;
  logic [9:0]  payload_index;
  logic [15:0] message_id;
  logic [10:0] frame_bytes;
  modport source (output valid, output event_code, output payload_byte,
                  output payload_index, output message_id, output frame_bytes,
                  input ready);
  modport sink (input valid, input event_code, input payload_byte,
                input payload_index, input message_id, input frame_bytes,
                output ready);
endinterface

@@ design/gnss_binary_frame_parser_crc32.sv @@
// Top level of the binary log frame parser with CRC-32 check.
// Depends on gbfp_pkg and the interfaces in gbfp_if.sv.
//
//  channel    | dir | handshake     | payload
//  -----------+-----+---------------+------------------------------------------
//  byte_in    | in  | valid/ready   | rx_byte[7:0]
//  event_out  | out | valid/ready   | event_code, payload_byte, payload_index,
//             |     |               | message_id, frame_bytes
//  cfg        | in  | cfg_we only   | cfg_index[1:0], cfg_data[7:0]
//
// One item per cycle while byte_in is ready: each byte is parsed and its CRC
// updated in the cycle it is accepted; its result is registered in the output
// or skid register. Every accepted byte gives exactly one result item.
// A skid register behind the output register keeps byte_in ready for one more
// item while a result is stalled; byte_in drops ready only when both are full.
// Synchronous reset returns to the first sync hunt with the default sync bytes.
module gnss_binary_frame_parser_crc32 #(
  parameter int HEADER_MAX    = 32,
  parameter int PAYLOAD_MAX   = 1024,
  parameter int LENGTH_OFFSET = 8,
  parameter int ID_OFFSET     = 4
) (
  input  logic        clk,
  input  logic        rst,
  gbfp_in_if.sink     byte_in,
  gbfp_out_if.source  event_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CNT_MAX = (PAYLOAD_MAX > HEADER_MAX) ? PAYLOAD_MAX : HEADER_MAX;
  localparam int CW      = $clog2(CNT_MAX + 1);
  localparam int SW      = 18;

  typedef enum logic [3:0] {
    PH_SYNC1 = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_SYNC3 = 4'd2,
    PH_HLEN  = 4'd3,
    PH_HDR   = 4'd4,
    PH_PAY   = 4'd5,
    PH_CRC0  = 4'd6,
    PH_CRC1  = 4'd7,
    PH_CRC2  = 4'd8,
    PH_CRC3  = 4'd9
  } phase_t;

  // Configuration registers
  logic [7:0] sync_first, sync_second, sync_third;

  // Parser state
  phase_t      phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]  header_len, header_len_next;
  logic [15:0] payload_len, payload_len_next;
  logic [15:0] msg_ident, msg_ident_next;
  logic [31:0] running_crc, running_crc_next;
  logic [23:0] received_crc, received_crc_next;

  // Output register and skid stage
  gbfp_pkg::result_t res, out_q, skid_q;
  logic out_valid, skid_valid;

  logic          accept;
  logic [7:0]    b;
  logic [31:0]   crc_upd;
  logic [CW-1:0] cnt_inc;
  logic [SW-1:0] frame_total;
  logic [SW-1:0] pay_pos;

  assign b       = byte_in.rx_byte;
  assign accept  = byte_in.valid && !skid_valid;
  assign byte_in.ready = !skid_valid;
  assign crc_upd = gbfp_pkg::crc_byte(running_crc, b);
  assign cnt_inc = byte_count + CW'(1);
  assign frame_total = SW'(payload_len) + SW'(header_len);
  assign pay_pos     = SW'(byte_count) - SW'(header_len);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= gbfp_pkg::SYNC_FIRST_RST;
      sync_second <= gbfp_pkg::SYNC_SECOND_RST;
      sync_third  <= gbfp_pkg::SYNC_THIRD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gbfp_pkg::REG_SYNC_FIRST:  sync_first  <= cfg_data;
        gbfp_pkg::REG_SYNC_SECOND: sync_second <= cfg_data;
        gbfp_pkg::REG_SYNC_THIRD:  sync_third  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parse one byte: next state and its result item
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    header_len_next   = header_len;
    payload_len_next  = payload_len;
    msg_ident_next    = msg_ident;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    res               = '0;
    res.event_code    = gbfp_pkg::EV_NONE;

    case (phase)
      PH_SYNC2: begin
        if (b == sync_second) begin
          running_crc_next = crc_upd;
          phase_next       = PH_SYNC3;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
      PH_SYNC3: begin
        if (b == sync_third) begin
          running_crc_next = crc_upd;
          phase_next       = PH_HLEN;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
      PH_HLEN: begin
        header_len_next  = b;
        msg_ident_next   = '0;
        payload_len_next = '0;
        if (b <= gbfp_pkg::FIXED_HEADER) begin
          res.event_code = gbfp_pkg::EV_ABORT;
          phase_next     = PH_SYNC1;
        end else begin
          running_crc_next = crc_upd;
          byte_count_next  = CW'(gbfp_pkg::FIXED_HEADER);
          phase_next       = PH_HDR;
        end
      end
      PH_HDR: begin
        if (byte_count >= CW'(HEADER_MAX)) begin
          res.event_code = gbfp_pkg::EV_ABORT;
          phase_next     = PH_SYNC1;
        end else begin
          // Capture little-endian header fields at their offsets
          if (byte_count == CW'(ID_OFFSET))          msg_ident_next[7:0]    = b;
          if (byte_count == CW'(ID_OFFSET + 1))      msg_ident_next[15:8]   = b;
          if (byte_count == CW'(LENGTH_OFFSET))      payload_len_next[7:0]  = b;
          if (byte_count == CW'(LENGTH_OFFSET + 1))  payload_len_next[15:8] = b;
          running_crc_next = crc_upd;
          byte_count_next  = cnt_inc;
          if (SW'(cnt_inc) >= SW'(header_len)) begin
            phase_next = (payload_len_next == 16'd0) ? PH_CRC0 : PH_PAY;
          end
        end
      end
      PH_PAY: begin
        if (byte_count >= CW'(PAYLOAD_MAX)) begin
          res.event_code = gbfp_pkg::EV_ABORT;
          phase_next     = PH_SYNC1;
        end else begin
          res.event_code    = gbfp_pkg::EV_PAYLOAD;
          res.payload_byte  = b;
          res.payload_index = pay_pos[9:0];
          res.message_id    = msg_ident;
          running_crc_next  = crc_upd;
          byte_count_next   = cnt_inc;
          if (SW'(cnt_inc) >= frame_total) phase_next = PH_CRC0;
        end
      end
      PH_CRC0: begin
        received_crc_next = {16'd0, b};
        phase_next        = PH_CRC1;
      end
      PH_CRC1: begin
        received_crc_next[15:8] = b;
        phase_next              = PH_CRC2;
      end
      PH_CRC2: begin
        received_crc_next[23:16] = b;
        phase_next               = PH_CRC3;
      end
      PH_CRC3: begin
        res.message_id = msg_ident;
        if ({b, received_crc} == running_crc) begin
          res.event_code  = gbfp_pkg::EV_GOOD;
          res.frame_bytes = SW'(byte_count) > 0 ? 11'(SW'(byte_count)) : 11'd0;
        end else begin
          res.event_code = gbfp_pkg::EV_BAD;
        end
        phase_next = PH_SYNC1;
      end
      default: begin
        // First sync hunt; unknown phases land here too
        phase_next = PH_SYNC1;
        if (b == sync_first) begin
          byte_count_next  = '0;
          running_crc_next = gbfp_pkg::crc_byte(32'd0, b);
          phase_next       = PH_SYNC2;
        end
      end
    endcase
  end

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      byte_count   <= '0;
      header_len   <= '0;
      payload_len  <= '0;
      msg_ident    <= '0;
      running_crc  <= '0;
      received_crc <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      header_len   <= header_len_next;
      payload_len  <= payload_len_next;
      msg_ident    <= msg_ident_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
    end
  end

  // Output register with skid stage: hold on stall, refill from skid first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !event_out.ready) begin
      if (accept) begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_q      <= skid_q;
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
      if (accept) out_q <= res;
    end
  end

  assign event_out.valid         = out_valid;
  assign event_out.event_code    = out_q.event_code;
  assign event_out.payload_byte  = out_q.payload_byte;
  assign event_out.payload_index = out_q.payload_index;
  assign event_out.message_id    = out_q.message_id;
  assign event_out.frame_bytes   = out_q.frame_bytes;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the binary log frame parser with CRC-32 check.
// Depends on gbfp_pkg, the interfaces in gbfp_if.sv and the parser top level.
module tb;

  localparam int HDR_MAX  = 32;
  localparam int BUF_MAX  = 1024;
  localparam int LEN_POS  = 8;
  localparam int ID_POS   = 4;
  localparam int SETTLE   = 8;
  localparam int LONG_HOLD = 150;

  typedef enum logic [3:0] {
    HUNT_A, HUNT_B, HUNT_C, GET_HLEN, GET_HDR, GET_PAY,
    GET_CRC0, GET_CRC1, GET_CRC2, GET_CRC3
  } framer_phase_t;

  typedef struct {
    logic [7:0] data;
    bit         wait_drain;
  } rx_entry_t;

  logic clk = 1'b0;
  logic rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  gbfp_in_if  byte_in ();
  gbfp_out_if event_out ();

  gnss_binary_frame_parser_crc32 #(
    .HEADER_MAX(HDR_MAX), .PAYLOAD_MAX(BUF_MAX),
    .LENGTH_OFFSET(LEN_POS), .ID_OFFSET(ID_POS)
  ) u_dut (
    .clk(clk), .rst(rst), .byte_in(byte_in), .event_out(event_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Sync bytes as last written, and the framer state that tracks the parser
  logic [7:0]    sync_a = gbfp_pkg::SYNC_FIRST_RST;
  logic [7:0]    sync_b = gbfp_pkg::SYNC_SECOND_RST;
  logic [7:0]    sync_c = gbfp_pkg::SYNC_THIRD_RST;
  framer_phase_t fr_phase = HUNT_A;
  int            fr_count = 0;
  logic [7:0]    fr_hlen = '0;
  logic [15:0]   fr_plen = '0;
  logic [15:0]   fr_id = '0;
  logic [31:0]   fr_crc = '0;
  logic [31:0]   fr_rx_crc = '0;

  gbfp_pkg::result_t framer_events[$];
  rx_entry_t rx_stream[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int n_payload = 0, n_good = 0, n_bad = 0, n_abort = 0;

  // Reflected CRC-32, one data bit at a time, LSB first
  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++)
      r = (r[0] ^ d[i]) ? ({1'b0, r[31:1]} ^ gbfp_pkg::CRC_POLY) : {1'b0, r[31:1]};
    return r;
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // Advance the framer by one accepted byte and queue the event it yields
  task automatic track_framer(input logic [7:0] b);
    gbfp_pkg::result_t r;
    r = '0;
    r.event_code = gbfp_pkg::EV_NONE;
    case (fr_phase)
      HUNT_B: begin
        if (b == sync_b) begin
          fr_crc = crc_update(fr_crc, b);
          fr_phase = HUNT_C;
        end else fr_phase = HUNT_A;
      end
      HUNT_C: begin
        if (b == sync_c) begin
          fr_crc = crc_update(fr_crc, b);
          fr_phase = GET_HLEN;
        end else fr_phase = HUNT_A;
      end
      GET_HLEN: begin
        fr_hlen = b;
        fr_id = '0;
        fr_plen = '0;
        if (b <= gbfp_pkg::FIXED_HEADER) begin
          r.event_code = gbfp_pkg::EV_ABORT;
          fr_phase = HUNT_A;
        end else begin
          fr_crc = crc_update(fr_crc, b);
          fr_count = gbfp_pkg::FIXED_HEADER;
          fr_phase = GET_HDR;
        end
      end
      GET_HDR: begin
        if (fr_count >= HDR_MAX) begin
          r.event_code = gbfp_pkg::EV_ABORT;
          fr_phase = HUNT_A;
        end else begin
          if (fr_count == ID_POS)      fr_id[7:0]    = b;
          if (fr_count == ID_POS + 1)  fr_id[15:8]   = b;
          if (fr_count == LEN_POS)     fr_plen[7:0]  = b;
          if (fr_count == LEN_POS + 1) fr_plen[15:8] = b;
          fr_crc = crc_update(fr_crc, b);
          fr_count++;
          if (fr_count >= int'(fr_hlen))
            fr_phase = (fr_plen == 0) ? GET_CRC0 : GET_PAY;
        end
      end
      GET_PAY: begin
        if (fr_count >= BUF_MAX) begin
          r.event_code = gbfp_pkg::EV_ABORT;
          fr_phase = HUNT_A;
        end else begin
          r.event_code = gbfp_pkg::EV_PAYLOAD;
          r.payload_byte = b;
          r.payload_index = 10'(fr_count - int'(fr_hlen));
          r.message_id = fr_id;
          fr_crc = crc_update(fr_crc, b);
          fr_count++;
          if (fr_count >= int'(fr_plen) + int'(fr_hlen)) fr_phase = GET_CRC0;
        end
      end
      GET_CRC0: begin
        fr_rx_crc = {24'd0, b};
        fr_phase = GET_CRC1;
      end
      GET_CRC1: begin
        fr_rx_crc[15:8] = b;
        fr_phase = GET_CRC2;
      end
      GET_CRC2: begin
        fr_rx_crc[23:16] = b;
        fr_phase = GET_CRC3;
      end
      GET_CRC3: begin
        fr_rx_crc[31:24] = b;
        r.message_id = fr_id;
        if (fr_rx_crc == fr_crc) begin
          r.event_code = gbfp_pkg::EV_GOOD;
          r.frame_bytes = 11'(fr_count);
        end else r.event_code = gbfp_pkg::EV_BAD;
        fr_phase = HUNT_A;
      end
      default: begin
        fr_phase = HUNT_A;
        if (b == sync_a) begin
          fr_count = 0;
          fr_crc = crc_update(32'd0, b);
          fr_phase = HUNT_B;
        end
      end
    endcase
    framer_events.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Driver: offer queued bytes, with random gaps and drain points
  int src_gap = 0;
  bit src_quiet = 1'b0;
  always @(posedge clk) begin
    logic offer;
    int   taken;
    if (rst) begin
      byte_in.valid <= 1'b0;
      byte_in.rx_byte <= '0;
      src_gap = 0;
    end else begin
      offer = byte_in.valid;
      taken = bytes_taken;
      if (byte_in.valid && byte_in.ready) begin
        track_framer(byte_in.rx_byte);
        taken++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (src_gap > 0) src_gap--;
        else if (rx_stream.size() > 0 &&
                 (!rx_stream[0].wait_drain || taken == results_seen)) begin
          byte_in.rx_byte <= rx_stream[0].data;
          void'(rx_stream.pop_front());
          offer = 1'b1;
          if ($urandom_range(0, 63) == 0) src_quiet = !src_quiet;
          src_gap = draw_wait(src_quiet);
        end
      end
      byte_in.valid <= offer;
      bytes_taken <= taken;
    end
  end

  // Monitor: check each result item against the oldest expected event
  int snk_stall = 0;
  int hold_left = 0;
  int hold_mark = 300;
  bit snk_quiet = 1'b0;
  always @(posedge clk) begin
    gbfp_pkg::result_t want;
    logic    fired;
    logic    nr;
    if (rst) begin
      event_out.ready <= 1'b0;
    end else begin
      fired = event_out.valid && event_out.ready;
      if (fired) begin
        if (results_seen >= bytes_taken) begin
          $error("result item with no expected event: event_code %0d",
                 event_out.event_code);
          error_count++;
        end else begin
          want = framer_events.pop_front();
          check_field("event_code", 16'(want.event_code), 16'(event_out.event_code));
          check_field("payload_byte", 16'(want.payload_byte),
                      16'(event_out.payload_byte));
          check_field("payload_index", 16'(want.payload_index),
                      16'(event_out.payload_index));
          check_field("message_id", want.message_id, event_out.message_id);
          check_field("frame_bytes", 16'(want.frame_bytes), 16'(event_out.frame_bytes));
          results_seen <= results_seen + 1;
          case (event_out.event_code)
            gbfp_pkg::EV_PAYLOAD: n_payload++;
            gbfp_pkg::EV_GOOD:    n_good++;
            gbfp_pkg::EV_BAD:     n_bad++;
            gbfp_pkg::EV_ABORT:   n_abort++;
            default: ;
          endcase
        end
      end
      // Long hold-off twice per run, otherwise short random stalls
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (results_seen >= hold_mark) begin
        hold_left = LONG_HOLD;
        hold_mark = hold_mark + 1200;
        nr = 1'b0;
      end else if (fired) begin
        if ($urandom_range(0, 63) == 0) snk_quiet = !snk_quiet;
        snk_stall = draw_wait(snk_quiet);
        nr = (snk_stall == 0);
      end else if (snk_stall > 0) begin
        snk_stall--;
        nr = (snk_stall == 0);
      end else nr = 1'b1;
      event_out.ready <= nr;
    end
  end

  task automatic push_byte(input logic [7:0] d, input bit drain);
    rx_entry_t e;
    e.data = d;
    e.wait_drain = drain;
    rx_stream.push_back(e);
    bytes_queued++;
  endtask

  // Queue one frame with the current sync bytes; payload length and id sit at
  // their header offsets only where the header reaches them
  task automatic add_frame(input logic [7:0] hlen, input logic [15:0] id,
                           input logic [15:0] plen, input bit corrupt, input bit drain);
    logic [7:0]  hdr [0:255];
    logic [31:0] crc;
    logic [15:0] eff_len;
    int          span;
    logic [7:0]  d;
    span = (hlen < 4) ? 4 : int'(hlen);
    for (int i = 0; i < span; i++) hdr[i] = 8'($urandom);
    hdr[0] = sync_a;
    hdr[1] = sync_b;
    hdr[2] = sync_c;
    hdr[3] = hlen;
    if (hlen > ID_POS)      hdr[ID_POS]      = id[7:0];
    if (hlen > ID_POS + 1)  hdr[ID_POS + 1]  = id[15:8];
    if (hlen > LEN_POS)     hdr[LEN_POS]     = plen[7:0];
    if (hlen > LEN_POS + 1) hdr[LEN_POS + 1] = plen[15:8];
    eff_len = {(hlen > LEN_POS + 1) ? plen[15:8] : 8'h00,
               (hlen > LEN_POS) ? plen[7:0] : 8'h00};
    crc = '0;
    for (int i = 0; i < span; i++) begin
      push_byte(hdr[i], drain && i == 0);
      crc = crc_update(crc, hdr[i]);
    end
    if (hlen > gbfp_pkg::FIXED_HEADER && hlen <= HDR_MAX) begin
      for (int i = 0; i < int'(eff_len); i++) begin
        d = 8'($urandom);
        push_byte(d, 1'b0);
        crc = crc_update(crc, d);
      end
      if (corrupt) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      for (int k = 0; k < 4; k++) push_byte(crc[8*k +: 8], 1'b0);
    end
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic random_traffic(input int n_bytes);
    int         target;
    int         pick;
    bit         drain;
    logic [7:0] hl;
    logic [15:0] pl;
    target = bytes_queued + n_bytes;
    while (bytes_queued < target) begin
      pick = $urandom_range(0, 99);
      drain = ($urandom_range(0, 49) == 0);
      hl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(10, HDR_MAX)) : 8'd28;
      pl = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(25, 300))
                                       : 16'($urandom_range(0, 24));
      if (pick < 78) begin
        add_frame(hl, 16'($urandom), pl, pick >= 68, drain);
      end else if (pick < 86) begin
        push_byte(sync_a, drain);
        if ($urandom_range(0, 1)) push_byte(sync_b, 1'b0);
        push_byte(8'($urandom), 1'b0);
      end else if (pick < 92) begin
        case ($urandom_range(0, 2))
          0: hl = 8'($urandom_range(0, 4));
          1: hl = 8'($urandom_range(5, 9));
          default: hl = 8'($urandom_range(HDR_MAX + 1, 60));
        endcase
        add_frame(hl, 16'($urandom), pl, 1'b0, drain);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Wait until every expected event has come back, then let the parser settle
  task automatic wait_idle();
    do @(negedge clk);
    while (rx_stream.size() != 0 || byte_in.valid || results_seen != bytes_taken);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gbfp_pkg::REG_SYNC_FIRST:  sync_a = val;
      gbfp_pkg::REG_SYNC_SECOND: sync_b = val;
      gbfp_pkg::REG_SYNC_THIRD:  sync_c = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] va, vb, vc;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = gbfp_pkg::REG_SYNC_FIRST;
    cfg_data = '0;
    byte_in.valid = 1'b0;
    byte_in.rx_byte = '0;
    event_out.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames under the reset sync bytes
    add_frame(8'd28, 16'h0000, 16'd4, 1'b0, 1'b0);
    add_frame(8'd32, 16'hFFFF, 16'd1, 1'b0, 1'b0);
    add_frame(8'd28, 16'h1234, 16'd0, 1'b0, 1'b0);
    add_frame(8'd28, 16'h00FF, 16'd2, 1'b1, 1'b0);
    // failed second sync byte equal to the first: not retried as a start
    push_byte(sync_a, 1'b0);
    push_byte(sync_a, 1'b0);
    add_frame(8'd28, 16'h5A5A, 16'd3, 1'b0, 1'b0);
    // failed third sync byte equal to the first
    push_byte(sync_a, 1'b0);
    push_byte(sync_b, 1'b0);
    push_byte(sync_a, 1'b0);
    add_frame(8'd28, 16'hA5A5, 16'd3, 1'b0, 1'b0);
    // short headers, headers that miss the id or length fields
    add_frame(8'd4, 16'h0001, 16'd0, 1'b0, 1'b0);
    add_frame(8'd0, 16'h0001, 16'd0, 1'b0, 1'b0);
    add_frame(8'd5, 16'hBEEF, 16'd7, 1'b0, 1'b0);
    add_frame(8'd9, 16'hCAFE, 16'h0305, 1'b0, 1'b0);
    add_frame(8'd10, 16'h0102, 16'h0100, 1'b0, 1'b0);
    // header overflow, then a payload that overruns the buffer on its last byte
    add_frame(8'd40, 16'h7777, 16'd2, 1'b0, 1'b0);
    add_frame(8'd25, 16'h8002, 16'd1000, 1'b0, 1'b0);
    // sender pause until everything has drained
    add_frame(8'd28, 16'h4321, 16'd5, 1'b0, 1'b1);
    random_traffic(60);

    // Walk through several sync settings, extremes among them
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      case (k)
        0: begin va = 8'h00; vb = 8'hFF; vc = 8'h00; end
        1: begin va = 8'hFF; vb = 8'hFF; vc = 8'hFF; end
        2: begin va = 8'($urandom); vb = 8'($urandom); vc = 8'($urandom); end
        default: begin
          va = gbfp_pkg::SYNC_FIRST_RST;
          vb = gbfp_pkg::SYNC_SECOND_RST;
          vc = gbfp_pkg::SYNC_THIRD_RST;
        end
      endcase
      write_reg(gbfp_pkg::REG_SYNC_FIRST, va);
      write_reg(gbfp_pkg::REG_SYNC_SECOND, vb);
      write_reg(gbfp_pkg::REG_SYNC_THIRD, vc);
      add_frame(8'd28, 16'($urandom), 16'd6, 1'b0, 1'b0);
      random_traffic(60);
    end

    wait_idle();
    $display("Run covered %0d bytes over five sync settings: %0d payload bytes,",
             bytes_taken, n_payload);
    $display("%0d good frames, %0d CRC mismatches and %0d aborted frames.",
             n_good, n_bad, n_abort);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run
  initial begin
    #20ms;
    $display("Timeout: parser stopped returning events");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
